// ===== rtl/core/msc_pkg.sv =====
package msc_pkg;

    localparam int MAX_TRACKS    = 8;
    localparam int TRACK_ID_BITS = 8;
    localparam int IDX_BITS      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_BITS      = $clog2(MAX_TRACKS + 1);
    localparam logic [63:0] DEFAULT_TIMEOUT = 64'd60000;

    typedef enum logic [3:0] {
        K_SETUP    = 4'd0,
        K_PLAY     = 4'd1,
        K_PAUSE    = 4'd2,
        K_ANNOUNCE = 4'd3,
        K_RECORD   = 4'd4,
        K_TEARDOWN = 4'd5,
        K_CSEQ     = 4'd6,
        K_TOUCH    = 4'd7,
        K_EXPIRY   = 4'd8,
        K_CONFLICT = 4'd9,
        K_CHANRES  = 4'd10,
        K_TRACKRES = 4'd11
    } kind_t;

    localparam logic [2:0] MODE_INIT      = 3'd0;
    localparam logic [2:0] MODE_READY     = 3'd1;
    localparam logic [2:0] MODE_PLAYING   = 3'd2;
    localparam logic [2:0] MODE_RECORDING = 3'd3;
    localparam logic [2:0] MODE_CLOSED    = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic                load;   // capture request
        logic                clear;  // reset scan index
        logic                step;   // examine one binding, advance on miss
        logic                finish; // commit state, drive result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic needs_scan;
    } dp_status_t;

endpackage

// ===== rtl/core/msc_ctrl.sv =====
module msc_ctrl
    import msc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:   if (start) state_reg <= S_DECIDE;
                S_DECIDE: state_reg <= status.needs_scan ? S_SCAN : S_FINISH;
                S_SCAN:   if (status.scan_done) state_reg <= S_FINISH;
                S_FINISH: state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && start;
        cmd.clear  = (state_reg == S_DECIDE);
        cmd.step   = (state_reg == S_SCAN) && !status.scan_done;
        cmd.finish = (state_reg == S_FINISH);
        busy       = (state_reg != S_IDLE);
    end

`ifndef SYNTH
    a_finish_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !busy) else $error("finish not followed by idle");
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy) else $error("load while busy");
    a_step_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> busy && !cmd.finish) else $error("step outside scan");
`endif

endmodule

// ===== rtl/core/msc_datapath.sv =====
module msc_datapath
    import msc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic                cfg_valid,
    input  logic [63:0]         cfg_data,
    input  logic [3:0]          kind,
    input  logic [7:0]          track_id,
    input  logic                track_present,
    input  logic                lower_transport,
    input  logic signed [8:0]   rtp_channel_req,
    input  logic signed [8:0]   rtcp_channel_req,
    input  logic [7:0]          section_count,
    input  logic [63:0]         fingerprint_hash,
    input  logic signed [31:0]  sequence_number,
    input  logic [63:0]         now_time,
    input  logic [7:0]          channel,
    output logic                result_valid,
    output logic                ok,
    output logic [2:0]          session_state_out,
    output logic                is_control,
    output logic [7:0]          found_track,
    output logic [7:0]          rtp_channel_out,
    output logic [7:0]          rtcp_channel_out,
    output logic                announced_out,
    output logic                transport_set,
    output logic signed [31:0]  last_sequence_out
);

    // request capture
    logic [3:0]               kind_reg;
    logic [TRACK_ID_BITS-1:0] track_reg;
    logic                     present_reg;
    logic                     tcp_reg;
    logic signed [8:0]        rtp_reg;
    logic signed [8:0]        rtcp_reg;
    logic [7:0]               mcount_reg;
    logic [63:0]              fhash_reg;
    logic signed [31:0]       seq_reg;
    logic [63:0]              now_reg;
    logic [7:0]               chan_reg;

    // session state
    logic [63:0]        timeout_reg;
    logic [2:0]         mode_reg;
    logic               tflag_reg;
    logic               aflag_reg;
    logic [7:0]         acount_reg;
    logic [63:0]        ahash_reg;
    logic signed [31:0] lseq_reg;
    logic [63:0]        lact_reg;
    logic [CNT_BITS-1:0] bcount_reg;

    // binding table
    logic [TRACK_ID_BITS-1:0] bt_track [MAX_TRACKS];
    logic                     bt_tcp   [MAX_TRACKS];
    logic signed [8:0]        bt_rtp   [MAX_TRACKS];
    logic signed [8:0]        bt_rtcp  [MAX_TRACKS];

    // scan
    logic [CNT_BITS-1:0]      idx_reg;
    logic                     hit_reg;
    logic [CNT_BITS-1:0]      hit_idx_reg;
    logic                     hctl_reg;
    logic                     exp_reg;

    logic [IDX_BITS-1:0]      idx;
    logic                     e_usable;
    logic                     match;
    logic                     m_ctl;
    logic [64:0]              diff;

    assign idx = idx_reg[IDX_BITS-1:0];
    assign e_usable = bt_tcp[idx] && !bt_rtp[idx][8] && !bt_rtcp[idx][8];
    assign diff = {1'b0, now_reg} - {1'b0, lact_reg};

    always_comb
    begin
        match = 1'b0;
        m_ctl = 1'b0;
        case (kind_reg) inside
            K_SETUP, K_TRACKRES:
                match = (bt_track[idx] == track_reg);
            K_CONFLICT:
                match = e_usable && (rtp_reg == bt_rtp[idx] || rtp_reg == bt_rtcp[idx]
                        || rtcp_reg == bt_rtp[idx] || rtcp_reg == bt_rtcp[idx]);
            K_CHANRES:
            begin
                if (bt_tcp[idx] && !bt_rtp[idx][8] && bt_rtp[idx][7:0] == chan_reg)
                begin
                    match = 1'b1;
                end
                else if (bt_tcp[idx] && !bt_rtcp[idx][8] && bt_rtcp[idx][7:0] == chan_reg)
                begin
                    match = 1'b1;
                    m_ctl = 1'b1;
                end
            end
            default: match = 1'b0;
        endcase
    end

    always_comb
    begin
        status.scan_done  = hit_reg || (idx_reg >= bcount_reg);
        status.needs_scan = (kind_reg == K_SETUP) || (kind_reg == K_CHANRES)
                         || (kind_reg == K_TRACKRES)
                         || ((kind_reg == K_CONFLICT) && tcp_reg && !rtp_reg[8]
                             && !rtcp_reg[8]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind;
            track_reg   <= track_id[TRACK_ID_BITS-1:0];
            present_reg <= track_present;
            tcp_reg     <= lower_transport;
            rtp_reg     <= rtp_channel_req;
            rtcp_reg    <= rtcp_channel_req;
            mcount_reg  <= section_count;
            fhash_reg   <= fingerprint_hash;
            seq_reg     <= sequence_number;
            now_reg     <= now_time;
            chan_reg    <= channel;
        end
        if (cmd.clear)
        begin
            exp_reg <= (lact_reg != 64'd0) && !diff[64] && (diff[63:0] > timeout_reg);
        end
        if (cmd.finish && kind_reg == K_SETUP && mode_reg != MODE_CLOSED && present_reg)
        begin
            if (hit_reg)
            begin
                bt_tcp[hit_idx_reg[IDX_BITS-1:0]]  <= tcp_reg;
                bt_rtp[hit_idx_reg[IDX_BITS-1:0]]  <= rtp_reg;
                bt_rtcp[hit_idx_reg[IDX_BITS-1:0]] <= rtcp_reg;
            end
            else if (bcount_reg < CNT_BITS'(MAX_TRACKS))
            begin
                bt_track[bcount_reg[IDX_BITS-1:0]] <= track_reg;
                bt_tcp[bcount_reg[IDX_BITS-1:0]]   <= tcp_reg;
                bt_rtp[bcount_reg[IDX_BITS-1:0]]   <= rtp_reg;
                bt_rtcp[bcount_reg[IDX_BITS-1:0]]  <= rtcp_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg       <= DEFAULT_TIMEOUT;
            mode_reg          <= MODE_INIT;
            tflag_reg         <= 1'b0;
            aflag_reg         <= 1'b0;
            acount_reg        <= '0;
            ahash_reg         <= '0;
            lseq_reg          <= -32'sd1;
            lact_reg          <= '0;
            bcount_reg        <= '0;
            idx_reg           <= '0;
            hit_reg           <= 1'b0;
            hit_idx_reg       <= '0;
            hctl_reg          <= 1'b0;
            result_valid      <= 1'b0;
            ok                <= 1'b0;
            session_state_out <= MODE_INIT;
            is_control        <= 1'b0;
            found_track       <= '0;
            rtp_channel_out   <= '0;
            rtcp_channel_out  <= '0;
            announced_out     <= 1'b0;
            transport_set     <= 1'b0;
            last_sequence_out <= -32'sd1;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_valid)
            begin
                timeout_reg <= (cfg_data == 64'd0) ? DEFAULT_TIMEOUT : cfg_data;
            end
            if (cmd.clear)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            if (cmd.step)
            begin
                if (match)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= idx_reg;
                    hctl_reg    <= m_ctl;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                logic               r_ok;
                logic               r_ctl;
                logic [7:0]         r_ft;
                logic [7:0]         r_rtp;
                logic [7:0]         r_rtcp;
                logic [2:0]         n_mode;
                logic               n_tflag;
                logic               n_aflag;
                logic signed [31:0] n_lseq;
                logic [IDX_BITS-1:0] h;
                r_ok    = 1'b0;
                r_ctl   = 1'b0;
                r_ft    = '0;
                r_rtp   = '0;
                r_rtcp  = '0;
                n_mode  = mode_reg;
                n_tflag = tflag_reg;
                n_aflag = aflag_reg;
                n_lseq  = lseq_reg;
                h       = hit_idx_reg[IDX_BITS-1:0];
                case (kind_reg)
                    K_SETUP:
                    begin
                        if (mode_reg != MODE_CLOSED && present_reg
                            && (hit_reg || bcount_reg < CNT_BITS'(MAX_TRACKS)))
                        begin
                            if (!hit_reg)
                            begin
                                bcount_reg <= bcount_reg + 1'b1;
                            end
                            n_tflag = 1'b1;
                            n_mode  = MODE_READY;
                            r_ok    = 1'b1;
                        end
                    end
                    K_PLAY:
                        if (mode_reg == MODE_READY)
                        begin
                            n_mode = MODE_PLAYING;
                            r_ok   = 1'b1;
                        end
                    K_PAUSE:
                        if (mode_reg == MODE_PLAYING)
                        begin
                            n_mode = MODE_READY;
                            r_ok   = 1'b1;
                        end
                    K_ANNOUNCE:
                        if (mode_reg == MODE_READY && bcount_reg != '0 && mcount_reg != 8'd0
                            && mcount_reg == 8'(bcount_reg)
                            && (!aflag_reg || (acount_reg == mcount_reg
                                && (ahash_reg == 64'd0 || fhash_reg == 64'd0
                                    || ahash_reg == fhash_reg))))
                        begin
                            n_aflag = 1'b1;
                            acount_reg <= mcount_reg;
                            ahash_reg  <= fhash_reg;
                            r_ok = 1'b1;
                        end
                    K_RECORD:
                        if (mode_reg == MODE_READY && aflag_reg)
                        begin
                            n_mode = MODE_RECORDING;
                            r_ok   = 1'b1;
                        end
                    K_TEARDOWN:
                    begin
                        n_tflag = 1'b0;
                        n_aflag = 1'b0;
                        acount_reg <= '0;
                        ahash_reg  <= '0;
                        bcount_reg <= '0;
                        n_mode = MODE_CLOSED;
                        r_ok   = 1'b1;
                    end
                    K_CSEQ:
                        if (!seq_reg[31] && (lseq_reg[31] || seq_reg > lseq_reg))
                        begin
                            n_lseq = seq_reg;
                            r_ok   = 1'b1;
                        end
                    K_TOUCH:
                    begin
                        lact_reg <= now_reg;
                        r_ok = 1'b1;
                    end
                    K_EXPIRY:  r_ok = exp_reg;
                    K_CONFLICT: r_ok = hit_reg;
                    K_CHANRES:
                        if (hit_reg)
                        begin
                            r_ok  = 1'b1;
                            r_ctl = hctl_reg;
                            r_ft  = 8'(bt_track[h]);
                        end
                    K_TRACKRES:
                        if (hit_reg && bt_tcp[h] && !bt_rtp[h][8] && !bt_rtcp[h][8])
                        begin
                            r_ok   = 1'b1;
                            r_rtp  = bt_rtp[h][7:0];
                            r_rtcp = bt_rtcp[h][7:0];
                        end
                    default: r_ok = 1'b0;
                endcase
                mode_reg          <= n_mode;
                tflag_reg         <= n_tflag;
                aflag_reg         <= n_aflag;
                lseq_reg          <= n_lseq;
                result_valid      <= 1'b1;
                ok                <= r_ok;
                session_state_out <= n_mode;
                is_control        <= r_ctl;
                found_track       <= r_ft;
                rtp_channel_out   <= r_rtp;
                rtcp_channel_out  <= r_rtcp;
                announced_out     <= n_aflag;
                transport_set     <= n_tflag;
                last_sequence_out <= n_lseq;
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bcount_reg <= CNT_BITS'(MAX_TRACKS)) else $error("binding count overflow");
    a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_CLOSED |=> mode_reg == MODE_CLOSED) else $error("left closed");
    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("result repeated");
`endif

endmodule

// ===== rtl/core/media_session_controller.sv =====
// session request controller
// input: pulse start with the request fields while busy is low; the request
// is taken at that edge and busy rises until the result is delivered.
// output: done is high for exactly one cycle with the result fields; the
// receiver cannot hold results off, so nothing waits inside the block.
// steps: a request is captured, decided and then finished; setup, channel
// resolve, track resolve and conflict checks on usable TCP channels first
// walk the binding table one entry a cycle, stopping at the first match.
// busy drops together with done, so the next request can be taken at the
// edge that ends the done cycle.
// config: cfg_valid/cfg_ready write session_timeout; cfg_ready is always
// high; a write of zero stores 60000. write only while idle.
// reset: rst_n clears the session to init, timeout to 60000, no bindings,
// last sequence -1, no announcement.
module media_session_controller
    import msc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [63:0]        cfg_data,
    input  logic [3:0]         kind,
    input  logic [7:0]         track_id,
    input  logic               track_present,
    input  logic               lower_transport,
    input  logic signed [8:0]  rtp_channel_req,
    input  logic signed [8:0]  rtcp_channel_req,
    input  logic [7:0]         section_count,
    input  logic [63:0]        fingerprint_hash,
    input  logic signed [31:0] sequence_number,
    input  logic [63:0]        now_time,
    input  logic [7:0]         channel,
    output logic               ok,
    output logic [2:0]         session_state_out,
    output logic               is_control,
    output logic [7:0]         found_track,
    output logic [7:0]         rtp_channel_out,
    output logic [7:0]         rtcp_channel_out,
    output logic               announced_out,
    output logic               transport_set,
    output logic signed [31:0] last_sequence_out
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    msc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    msc_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_valid         (cfg_valid),
        .cfg_data          (cfg_data),
        .kind              (kind),
        .track_id          (track_id),
        .track_present     (track_present),
        .lower_transport   (lower_transport),
        .rtp_channel_req   (rtp_channel_req),
        .rtcp_channel_req  (rtcp_channel_req),
        .section_count     (section_count),
        .fingerprint_hash  (fingerprint_hash),
        .sequence_number   (sequence_number),
        .now_time          (now_time),
        .channel           (channel),
        .result_valid      (done),
        .ok                (ok),
        .session_state_out (session_state_out),
        .is_control        (is_control),
        .found_track       (found_track),
        .rtp_channel_out   (rtp_channel_out),
        .rtcp_channel_out  (rtcp_channel_out),
        .announced_out     (announced_out),
        .transport_set     (transport_set),
        .last_sequence_out (last_sequence_out)
    );

endmodule
